>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fas_pkg.sv
package fas_pkg;

  // Default sizing
  localparam int MAX_FRAMES_DEF    = 16;
  localparam int DURATION_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF     = 8;

  // Fixed port widths
  localparam int DUR_IN_W = 16;
  localparam int DELTA_W  = 24;
  localparam int FIDX_W   = 4;

  // Request codes
  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_ADVANCE = 2'd2
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_ZERO    = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_ADD,
    S_CMP,
    S_MOD,
    S_SCAN_RD,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

>>> rtl/frame_animation_sequencer.sv
// Keyframe animation timer. Requests: append a frame duration (ms), restart, or
// advance by a positive fixed-point delta (FRAC_BITS fraction bits). Each request
// gives one result: frame index, finished, initialized and status. All arithmetic
// runs through one shared add/subtract unit under a small sequencer, one request
// at a time; in_ready is high only while the sequencer is idle. Restart and
// ignored requests go straight to the result; append first adds to the total.
// Advance adds the delta; reaching the total, loop mode wraps via the restoring
// remainder loop over W bits (30 by default), else it clamps; the frames are then
// scanned one per cycle from the duration memory to find the current one.
// A finished result waits in the output register while the next request starts.
`include "assert_macros.svh"

module frame_animation_sequencer #(
  parameter int MAX_FRAMES    = fas_pkg::MAX_FRAMES_DEF,
  parameter int DURATION_BITS = fas_pkg::DURATION_BITS_DEF,
  parameter int FRAC_BITS     = fas_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [fas_pkg::DUR_IN_W-1:0] frame_duration,
  input  logic signed [fas_pkg::DELTA_W-1:0] delta_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fas_pkg::FIDX_W-1:0]  frame_index,
  output logic                        finished,
  output logic                        initialized,
  output logic [1:0]                  status
);

  import fas_pkg::*;

  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TOT_W     = DURATION_BITS + CNT_W;
  localparam int E_W       = TOT_W + FRAC_BITS;
  localparam int W         = ((E_W > DELTA_W - 1) ? E_W : DELTA_W - 1) + 1;
  localparam int BC_W      = $clog2(W);
  localparam int DUR_EXT_W = (DURATION_BITS > DUR_IN_W) ? DURATION_BITS : DUR_IN_W;

  state_t state, state_next;

  // Architectural state
  logic                     loop_en;
  logic [CNT_W-1:0]         count;
  logic [TOT_W-1:0]         total;
  logic [E_W-1:0]           elapsed;
  logic [IDX_W-1:0]         cur_frame;

  // Working registers
  logic [W-1:0]             t_acc;
  logic [W-1:0]             rem;
  logic [BC_W-1:0]          bit_cnt;
  logic [IDX_W-1:0]         idx;
  logic [DURATION_BITS-1:0] dur_r;
  status_t                  st_r;

  // Decoded request
  logic                     in_fire;
  logic [DUR_EXT_W-1:0]     dur_ext;
  logic [DURATION_BITS-1:0] dur_m;
  logic                     has_room;
  logic                     app_ok;
  logic                     adv_ok;
  logic                     last_frame;
  logic                     out_load;
  status_t                  st_in;

  // Shared unit and memory
  logic [W-1:0]             alu_a, alu_b, alu_sum;
  logic                     alu_sub, alu_carry;
  logic [W-1:0]             tot_fx, dur_fx, rem_sh, rem_new;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [DURATION_BITS-1:0] ram_rdata;
  logic [IDX_W+FIDX_W-1:0]  cf_ext;

  fas_ram #(
    .WIDTH(DURATION_BITS),
    .DEPTH(MAX_FRAMES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(dur_m),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fas_alu #(
    .W(W)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .carry(alu_carry)
  );

  // Request decode
  always_comb begin
    in_fire    = in_valid && in_ready;
    dur_ext    = DUR_EXT_W'(frame_duration);
    dur_m      = dur_ext[DURATION_BITS-1:0];
    has_room   = count < CNT_W'(MAX_FRAMES);
    app_ok     = (dur_m != '0) && has_room;
    adv_ok     = (count != '0) && !delta_time[DELTA_W-1] && (delta_time != '0);
    tot_fx     = W'(total) << FRAC_BITS;
    dur_fx     = W'(ram_rdata) << FRAC_BITS;
    rem_sh     = {rem[W-2:0], t_acc[W-1]};
    rem_new    = alu_carry ? alu_sum : rem_sh;
    last_frame = (CNT_W'(idx) + CNT_W'(1)) == count;
    out_load   = !out_valid || out_ready;
    cf_ext     = (IDX_W + FIDX_W)'(cur_frame);
    // Status the request will report; zero duration is checked before a full table
    if (req_type == REQ_APPEND) begin
      if (dur_m == '0) begin
        st_in = STAT_ZERO;
      end else if (!has_room) begin
        st_in = STAT_FULL;
      end else begin
        st_in = STAT_OK;
      end
    end else if (req_type == REQ_RESTART) begin
      st_in = STAT_OK;
    end else if (req_type == REQ_ADVANCE && adv_ok) begin
      st_in = STAT_OK;
    end else begin
      st_in = STAT_IGNORED;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_APPEND && app_ok) begin
            state_next = S_APPEND;
          end else if (req_type == REQ_ADVANCE && adv_ok) begin
            state_next = S_ADD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_APPEND:  state_next = S_DONE;
      S_ADD:     state_next = S_CMP;
      S_CMP:     state_next = (alu_carry && loop_en) ? S_MOD : S_SCAN_RD;
      S_MOD:     state_next = (bit_cnt == '0) ? S_SCAN_RD : S_MOD;
      S_SCAN_RD: state_next = S_SCAN;
      S_SCAN:    state_next = (!alu_carry || last_frame) ? S_DONE : S_SCAN;
      S_DONE:    state_next = out_load ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control outputs: handshake, memory and shared unit operands
  always_comb begin
    in_ready  = (state == S_IDLE);
    ram_we    = (state == S_IDLE) && in_valid && (req_type == REQ_APPEND) && app_ok;
    ram_raddr = '0;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    case (state)
      S_APPEND: begin
        alu_a = W'(total);
        alu_b = W'(dur_r);
      end
      S_ADD: begin
        alu_a = W'(elapsed);
        alu_b = t_acc;
      end
      S_CMP: begin
        alu_a   = t_acc;
        alu_b   = tot_fx;
        alu_sub = 1'b1;
      end
      S_MOD: begin
        alu_a   = rem_sh;
        alu_b   = tot_fx;
        alu_sub = 1'b1;
      end
      S_SCAN: begin
        alu_a     = rem;
        alu_b     = dur_fx;
        alu_sub   = 1'b1;
        ram_raddr = idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      loop_en <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        loop_en <= cfg_data;
      end
    end
  end

  // Animation state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      elapsed   <= '0;
      cur_frame <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            dur_r <= dur_m;
            t_acc <= W'(delta_time[DELTA_W-2:0]);
            st_r  <= st_in;
            if (req_type == REQ_RESTART) begin
              elapsed   <= '0;
              cur_frame <= '0;
            end
          end
        end
        S_APPEND: begin
          total <= alu_sum[TOT_W-1:0];
          count <= count + CNT_W'(1);
        end
        S_ADD: begin
          t_acc <= alu_sum;
        end
        // Wrap, clamp or keep the new time
        S_CMP: begin
          rem     <= '0;
          bit_cnt <= BC_W'(W - 1);
          if (!alu_carry) begin
            elapsed <= t_acc[E_W-1:0];
          end else if (!loop_en) begin
            elapsed <= tot_fx[E_W-1:0];
          end
        end
        // Restoring remainder, one bit per cycle
        S_MOD: begin
          rem     <= rem_new;
          t_acc   <= t_acc << 1;
          bit_cnt <= bit_cnt - BC_W'(1);
          if (bit_cnt == '0) begin
            elapsed <= rem_new[E_W-1:0];
          end
        end
        S_SCAN_RD: begin
          rem <= W'(elapsed);
          idx <= '0;
        end
        // Peel off one frame per cycle until the time falls inside it or the last frame is reached
        S_SCAN: begin
          if (!alu_carry || last_frame) begin
            cur_frame <= idx;
          end else begin
            rem <= alu_sum;
            idx <= idx + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_load) begin
      out_valid   <= 1'b1;
      frame_index <= cf_ext[FIDX_W-1:0];
      finished    <= !loop_en && (count != '0) && (W'(elapsed) == tot_fx);
      initialized <= (count != '0);
      status      <= st_r;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_time_in_range, clk, rst, W'(elapsed) <= tot_fx, "elapsed time beyond total")
  `ASSERT_ALWAYS(a_count_in_range, clk, rst, count <= CNT_W'(MAX_FRAMES), "frame count overflow")
  `ASSERT_IMPLY(a_scan_bound, clk, rst, state == S_SCAN, CNT_W'(idx) < count, "scan past last frame")
  `ASSERT_NEXT(a_restart_clears, clk, rst, in_fire && req_type == REQ_RESTART, elapsed == '0 && cur_frame == '0, "restart did not clear time")

endmodule

>>> rtl/fas_ram.sv
module fas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fas_alu.sv
module fas_alu #(
  parameter int W = 30
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  // Add, or subtract by inverted operand plus one; carry set means a >= b on subtract
  always_comb begin
    full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    sum   = full[W-1:0];
    carry = full[W];
  end

endmodule

>>> tb/fas_timeline_checker.sv
`timescale 1ns / 100ps

// Watches both request and result channels, keeps its own copy of the frame
// table and timeline, and compares every result with the oldest prediction.
module fas_timeline_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [fas_pkg::DUR_IN_W-1:0]        frame_duration,
  input  logic signed [fas_pkg::DELTA_W-1:0]  delta_time,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [fas_pkg::FIDX_W-1:0]          frame_index,
  input  logic                                finished,
  input  logic                                initialized,
  input  logic [1:0]                          status,
  output int                                  fail_count,
  output int                                  pending
);

  import fas_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SLOTS = MAX_FRAMES_DEF;

  typedef struct packed {
    logic [FIDX_W-1:0] frame;
    logic              done;
    logic              init;
    status_t           stat;
  } anim_result_t;

  // Shadow timeline state
  logic [DURATION_BITS_DEF-1:0] dur_table [SLOTS];
  logic [4:0]                   frames_stored;
  logic [19:0]                  total_ms;
  logic [27:0]                  elapsed_fx;
  logic [FIDX_W-1:0]            cur_frame;
  logic                         loop_on;

  anim_result_t expected_results [$];
  int           mismatches;

  // Applies one request to the shadow timeline and returns the result it gives
  function automatic anim_result_t step_timeline(logic [1:0] req,
                                                  logic [DUR_IN_W-1:0] dur,
                                                  logic signed [DELTA_W-1:0] delta);
    anim_result_t res;
    logic [28:0]  t;
    logic [27:0]  tot_fx;
    logic [27:0]  cum;
    logic         found;
    res.stat = STAT_IGNORED;
    tot_fx = 28'(total_ms) << FRAC;
    case (req)
      REQ_APPEND: begin
        if (dur == '0) begin
          res.stat = STAT_ZERO;
        end else if (frames_stored >= 5'(SLOTS)) begin
          res.stat = STAT_FULL;
        end else begin
          dur_table[frames_stored[3:0]] = dur;
          frames_stored = frames_stored + 5'd1;
          total_ms = total_ms + 20'(dur);
          res.stat = STAT_OK;
        end
      end
      REQ_RESTART: begin
        elapsed_fx = '0;
        cur_frame = '0;
        res.stat = STAT_OK;
      end
      REQ_ADVANCE: begin
        if (frames_stored != '0 && !delta[DELTA_W-1] && delta != '0) begin
          t = 29'(elapsed_fx) + 29'(delta[DELTA_W-2:0]);
          // wrap or clamp at the end of the timeline
          if (t >= 29'(tot_fx))
            t = loop_on ? (t % 29'(tot_fx)) : 29'(tot_fx);
          elapsed_fx = t[27:0];
          // first frame whose cumulative end lies beyond the time, else the last
          cum = '0;
          found = 1'b0;
          cur_frame = FIDX_W'(frames_stored - 5'd1);
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && i < frames_stored) begin
              cum = cum + (28'(dur_table[i]) << FRAC);
              if (elapsed_fx < cum) begin
                cur_frame = FIDX_W'(i);
                found = 1'b1;
              end
            end
          end
          res.stat = STAT_OK;
        end
      end
      default: res.stat = STAT_IGNORED;
    endcase
    tot_fx = 28'(total_ms) << FRAC;
    res.frame = cur_frame;
    res.init = frames_stored != '0;
    res.done = res.init && !loop_on && elapsed_fx >= tot_fx;
    return res;
  endfunction

  always @(posedge clk) begin
    anim_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) dur_table[i] = '0;
      frames_stored = '0;
      total_ms = '0;
      elapsed_fx = '0;
      cur_frame = '0;
      loop_on = 1'b1;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_write)
        loop_on = cfg_data;
      // result side first: a result taken with a new request belongs to an older one
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: frame %0d fin %0b init %0b status %0d",
                     frame_index, finished, initialized, status);
        end else begin
          want = expected_results.pop_front();
          if (frame_index !== want.frame || finished !== want.done ||
              initialized !== want.init || status !== want.stat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected frame %0d fin %0b init %0b status %0d, got frame %0d fin %0b init %0b status %0d",
                       want.frame, want.done, want.init, want.stat,
                       frame_index, finished, initialized, status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(step_timeline(req_type, frame_duration, delta_time));
    end
    fail_count <= mismatches;
    pending <= expected_results.size();
  end

endmodule

>>> tb/tb_frame_animation_sequencer.sv
`timescale 1ns / 100ps

module tb_frame_animation_sequencer;
  import fas_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_GAP = 40;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                req_type;
  logic [DUR_IN_W-1:0]       frame_duration;
  logic signed [DELTA_W-1:0] delta_time;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [FIDX_W-1:0]         frame_index;
  logic                      finished;
  logic                      initialized;
  logic [1:0]                status;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  frame_animation_sequencer u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .frame_duration (frame_duration),
    .delta_time     (delta_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_index    (frame_index),
    .finished       (finished),
    .initialized    (initialized),
    .status         (status)
  );

  fas_timeline_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .frame_duration (frame_duration),
    .delta_time     (delta_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_index    (frame_index),
    .finished       (finished),
    .initialized    (initialized),
    .status         (status),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, after a random idle gap; returns on the falling edge after acceptance
  task automatic send_req(input logic [1:0] kind, input logic [DUR_IN_W-1:0] dur,
                          input logic [DELTA_W-1:0] dt);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    frame_duration <= dur;
    delta_time <= dt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds off new requests until every outstanding result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_loop(input logic value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly forward advances of mixed size, with appends, restarts and junk sprinkled in
  task automatic send_random();
    int                  pick;
    logic [DUR_IN_W-1:0] dur;
    logic [DELTA_W-1:0]  dt;
    pick = $urandom_range(99);
    dur = DUR_IN_W'($urandom);
    dt = DELTA_W'($urandom);
    if (pick < 8) begin
      send_req(REQ_APPEND, ($urandom_range(9) == 0) ? '0 : dur, dt);
    end else if (pick < 18) begin
      send_req(REQ_RESTART, dur, dt);
    end else if (pick < 22) begin
      send_req(REQ_UNUSED, dur, dt);
    end else if (pick < 30) begin
      // zero or negative delta
      send_req(REQ_ADVANCE, dur, ($urandom_range(3) == 0) ? '0 : {1'b1, dt[DELTA_W-2:0]});
    end else begin
      case ($urandom_range(3))
        0: dt = DELTA_W'($urandom_range(255, 1));
        1: dt = DELTA_W'($urandom_range(65535, 256));
        2: dt = DELTA_W'($urandom_range(8388607, 65536));
        default: dt = {1'b0, dt[DELTA_W-2:0] | 23'd1};
      endcase
      send_req(REQ_ADVANCE, dur, dt);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_APPEND;
    frame_duration = '0;
    delta_time = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_loop(1'b1);

    // Directed: empty table, rejects, unused code, field extremes, full table
    send_req(REQ_ADVANCE, 16'd0, 24'd256);
    send_req(REQ_RESTART, 16'hFFFF, 24'hFFFFFF);
    send_req(REQ_APPEND, 16'd0, 24'd0);
    send_req(REQ_UNUSED, 16'd7, 24'd100);
    send_req(REQ_APPEND, 16'hFFFF, 24'd0);
    send_req(REQ_APPEND, 16'd1, 24'd0);
    send_req(REQ_APPEND, 16'hAAAA, 24'd0);
    send_req(REQ_ADVANCE, 16'd0, 24'd0);
    send_req(REQ_ADVANCE, 16'd0, 24'h800000);
    send_req(REQ_ADVANCE, 16'd0, 24'd1);
    send_req(REQ_ADVANCE, 16'd0, 24'h7FFFFF);
    for (int i = 0; i < 13; i++)
      send_req(REQ_APPEND, DUR_IN_W'($urandom_range(300, 1)), 24'd0);
    send_req(REQ_APPEND, 16'd5, 24'd0);

    // Random phases: loop mode alternates and flips in the second half, idling pattern steps through all four
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_loop((ph < 4) ? ph[0] : !ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_random();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fas_pkg.sv
rtl/fas_ram.sv
rtl/fas_alu.sv
rtl/frame_animation_sequencer.sv
tb/fas_timeline_checker.sv
tb/tb_frame_animation_sequencer.sv
